### rtl/itoar_pkg.sv
// itoar_pkg: shared constants and character mapping for the radix text converter
`default_nettype none
package itoar_pkg;

	localparam int RADIX_W = 5;
	localparam int CHAR_W = 8;
	localparam int DIGIT_W = 4;
	localparam int STEP_BITS = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [CHAR_W-1:0] MINUS_CODE = 8'd45;
	localparam logic [CHAR_W-1:0] ZERO_CODE = 8'd48;
	localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'd55;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_W'(10)) begin
			c = ZERO_CODE + CHAR_W'(d);
		end else begin
			c = ALPHA_BASE + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/integer_to_ascii_radix.sv
// integer_to_ascii_radix: signed integer to ASCII text in base 2 to 16, one character per beat
// after start the digits are divided out one by one, then a minus sign if negative and the digits leave
// each digit comes from a shared divide step that moves 8 quotient bits a cycle
// the next start is taken during the last beat of an item
// characters leave on consecutive cycles and the receiver cannot stall them
// arst_n clears the control state and sets radix to 10; the digit stack is not reset
`default_nettype none
module integer_to_ascii_radix import itoar_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          strobe,
	output logic [CHAR_W-1:0]             character,
	output logic                          last_char,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [RADIX_W-1:0]            cfg_data
);

	localparam int CYC = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PW = CYC * STEP_BITS;
	localparam int PH_W = (CYC > 1) ? $clog2(CYC) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SIGN, ST_EMIT} state_t;

	state_t                 state_q;
	logic [RADIX_W-1:0]     radix_q;
	logic                   neg_q;
	logic [PW-1:0]          quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [PH_W-1:0]        phase_q;
	logic [CW-1:0]          cnt_q;
	logic [DIGIT_W-1:0]     stack_q [MAX_DIGITS];
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   strobe_q;

	logic [RADIX_W-1:0]     base;
	logic [VALUE_WIDTH-1:0] mag;
	logic [RADIX_W-1:0]     r;
	logic [STEP_BITS-1:0]   qb;
	logic [PW-1:0]          quo_nx;
	logic [DIGIT_W-1:0]     rem_nx;
	logic                   last_phase;
	logic                   push;
	logic                   pop;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign strobe    = strobe_q;
	assign character = char_q;
	assign last_char = last_q;

	// clamp out-of-range radix values
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	assign mag = value[VALUE_WIDTH-1] ? (~VALUE_WIDTH'(value) + 1'b1) : VALUE_WIDTH'(value);

	// eight restoring divide steps on the top byte of the quotient register
	always_comb begin
		r  = {1'b0, rem_q};
		qb = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {r[DIGIT_W-1:0], quo_q[PW-1-i]};
			if (r >= base) begin
				r = r - base;
				qb[STEP_BITS-1-i] = 1'b1;
			end
		end
		quo_nx = (quo_q << STEP_BITS) | PW'(qb);
		rem_nx = r[DIGIT_W-1:0];
	end

	assign last_phase = (phase_q == PH_W'(CYC - 1));
	assign push       = (state_q == ST_DIV) && last_phase;
	assign pop        = (state_q == ST_EMIT);

	// digit stack, most recent digit at the bottom
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[0] <= rem_nx;
			for (int i = 1; i < MAX_DIGITS; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			radix_q  <= RADIX_RESET;
			neg_q    <= 1'b0;
			quo_q    <= '0;
			rem_q    <= '0;
			phase_q  <= '0;
			cnt_q    <= '0;
			char_q   <= '0;
			last_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				radix_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						neg_q   <= value[VALUE_WIDTH-1];
						quo_q   <= PW'(mag);
						rem_q   <= '0;
						phase_q <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= quo_nx;
					if (last_phase) begin
						rem_q   <= '0;
						phase_q <= '0;
						cnt_q   <= cnt_q + CW'(1);
						if ((quo_nx == '0) || ((cnt_q + CW'(1)) == CW'(MAX_DIGITS))) begin
							state_q <= neg_q ? ST_SIGN : ST_EMIT;
						end
					end else begin
						rem_q   <= rem_nx;
						phase_q <= phase_q + PH_W'(1);
					end
				end
				ST_SIGN: begin
					char_q   <= MINUS_CODE;
					last_q   <= 1'b0;
					strobe_q <= 1'b1;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					char_q   <= digit_char(stack_q[0]);
					last_q   <= (cnt_q == CW'(1));
					strobe_q <= 1'b1;
					cnt_q    <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/itoar_chk.sv
// itoar_chk: port-level checks on the radix text converter, bound to the top level
`default_nettype none
module itoar_chk import itoar_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [CHAR_W-1:0] character,
	input logic              last_char
);

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("itoar_chk: busy not raised after accepted item");

	// characters of one string come on consecutive cycles
	a_string_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_char |=> strobe)
		else $error("itoar_chk: gap inside a string");

	// nothing follows the final character straight away
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_char |=> !strobe)
		else $error("itoar_chk: beat right after final character");

	// a minus sign never ends a string
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (character == MINUS_CODE) |-> !last_char)
		else $error("itoar_chk: string ends in a minus sign");

	// every beat carries a legal character
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == MINUS_CODE) ||
			((character >= 8'd48) && (character <= 8'd57)) ||
			((character >= 8'd65) && (character <= 8'd70)))
		else $error("itoar_chk: illegal character code");

endmodule

bind integer_to_ascii_radix itoar_chk u_itoar_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.character (character),
	.last_char (last_char)
);
`default_nettype wire
